@@ hw/rtl/prd_pkg.sv @@
package prd_pkg;

   // Fixed field widths
   localparam int FOV_W      = 17;
   localparam int DIM_W      = 13;
   localparam int QUAT_W     = 16;
   localparam int DIR_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   // Parameter defaults
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 14;

   // Register reset values
   localparam logic [FOV_W-1:0]         FOV_RESET    = 17'd25736;
   localparam logic [DIM_W-1:0]         WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]         HEIGHT_RESET = 13'd480;
   localparam logic signed [QUAT_W-1:0] QW_RESET     = 16'sd16384;
   localparam logic signed [QUAT_W-1:0] QV_RESET     = 16'sd0;

   // Angle constants in Q30
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint GAIN_Q30    = 64'sd652032874;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FOV    = 3'd0,
      CSR_WIDTH  = 3'd1,
      CSR_HEIGHT = 3'd2,
      CSR_QW     = 3'd3,
      CSR_QX     = 3'd4,
      CSR_QY     = 3'd5,
      CSR_QZ     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] x;
      logic signed [DIR_W-1:0] y;
      logic signed [DIR_W-1:0] z;
   } dir_type;

   // Round a Q30 constant to f fraction bits, half up
   function automatic longint from_q30(input longint v, input int f);
      int s;
      s = 30 - f;
      if (s == 0) begin
         return v;
      end
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   // atan(2^-i) in Q30
   function automatic longint atan_q30(input int i);
      case (i)
         0: return 64'sd843314857;
         1: return 64'sd497837829;
         2: return 64'sd263043837;
         3: return 64'sd133525159;
         4: return 64'sd67021688;
         5: return 64'sd33543516;
         6: return 64'sd16775851;
         7: return 64'sd8388437;
         8: return 64'sd4194283;
         9: return 64'sd2097149;
         default: return longint'(1) << (30 - i);
      endcase
   endfunction

endpackage

@@ hw/rtl/pixel_ray_direction_rotate_top.sv @@
// Channel   Direction  Handshake             Word
// req       in         req_valid/req_ready   req_pixel_x, req_pixel_y
// rsp       out        rsp_valid/rsp_ready   rsp_dir_x, rsp_dir_y, rsp_dir_z
// csr       in         csr_we (no wait)      csr_addr, csr_wdata
//
// One word enters per cycle while the output buffer has a free entry. Most of the pipe lies
// in the restoring divider (one quotient bit per stage), the three-stage mod-2pi reduction
// and the CORDIC stages.
// Synchronous reset clears valid bits, the output buffer and the registers to defaults.
// A two-word output buffer lets one result wait while the pipe still advances; the whole
// pipe holds only while both buffer entries are full.
module pixel_ray_direction_rotate_top
   import prd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_BITS-1:0]   req_pixel_x,
   input  logic [COORD_BITS-1:0]   req_pixel_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [DIR_W-1:0] rsp_dir_x,
   output logic signed [DIR_W-1:0] rsp_dir_y,
   output logic signed [DIR_W-1:0] rsp_dir_z,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int D_W    = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
   localparam int MAG_W  = FOV_W + D_W;
   localparam int NUM_W  = MAG_W + 2;
   localparam int DEN_W  = DIM_W + 2;
   localparam int ANG_W  = ((NUM_W > FRAC_BITS + 2) ? NUM_W : FRAC_BITS + 2) + 2;
   localparam int C_W    = FRAC_BITS + 4;
   localparam int V_W    = C_W;
   localparam int M_W    = 2 * C_W + 1;
   localparam int QP_W   = V_W + QUAT_W;
   localparam int PS_W   = QP_W + 3;
   localparam int P_W    = PS_W - FRAC_BITS;
   localparam int RP_W   = P_W + QUAT_W;
   localparam int RS_W   = RP_W + 3;
   localparam int R_W    = RS_W - FRAC_BITS;
   localparam int SAT_A  = (R_W > FRAC_BITS + 2) ? R_W : FRAC_BITS + 2;
   localparam int SAT_W  = ((SAT_A > DIR_W) ? SAT_A : DIR_W) + 1;

   localparam logic signed [ANG_W-1:0] HALF_A = ANG_W'(from_q30(HALF_PI_Q30, FRAC_BITS));
   localparam logic signed [M_W-1:0]   RND_M  = M_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PS_W-1:0]  RND_P  = PS_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [RS_W-1:0]  RND_R  = RS_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SAT_W-1:0] LIM    = SAT_W'(1) <<< FRAC_BITS;

   // ---------------------------------------------------------------- registers
   logic [FOV_W-1:0]         fov_ff;
   logic [DIM_W-1:0]         width_ff;
   logic [DIM_W-1:0]         height_ff;
   logic signed [QUAT_W-1:0] qw_ff;
   logic signed [QUAT_W-1:0] qx_ff;
   logic signed [QUAT_W-1:0] qy_ff;
   logic signed [QUAT_W-1:0] qz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff    <= FOV_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         qw_ff     <= QW_RESET;
         qx_ff     <= QV_RESET;
         qy_ff     <= QV_RESET;
         qz_ff     <= QV_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FOV:    fov_ff    <= csr_wdata[FOV_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_QW:     qw_ff     <= csr_wdata[QUAT_W-1:0];
            CSR_QX:     qx_ff     <= csr_wdata[QUAT_W-1:0];
            CSR_QY:     qy_ff     <= csr_wdata[QUAT_W-1:0];
            CSR_QZ:     qz_ff     <= csr_wdata[QUAT_W-1:0];
            default:    ;
         endcase
      end
   end

   // Zero width counts as one. Registers are to change only while the pipe is empty;
   // the user must keep to this, the block does not enforce it, and every stage reads them directly.
   logic [DIM_W-1:0] width_eff;
   assign width_eff = (width_ff == '0) ? DIM_W'(1) : width_ff;

   // ---------------------------------------------------------------- flow control
   logic [1:0] cnt_ff;
   logic       adv;
   logic       push;
   logic       pop;

   // advance whenever the output buffer has a free entry
   assign adv       = (cnt_ff != 2'd2);
   assign req_ready = adv;

   // ---------------------------------------------------------------- S1: offsets
   logic signed [D_W:0] dx_in;
   logic signed [D_W:0] dy_in;
   logic [D_W-1:0]      absx_ff;
   logic [D_W-1:0]      absy_ff;
   logic                s1_nx_ff;
   logic                s1_ny_ff;
   logic                s1_vld_ff;

   // 2*pixel - W and 2*pixel - H
   assign dx_in = signed'((D_W + 1)'({req_pixel_x, 1'b0})) - signed'((D_W + 1)'(width_eff));
   assign dy_in = signed'((D_W + 1)'({req_pixel_y, 1'b0})) - signed'((D_W + 1)'(height_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         absx_ff  <= dx_in[D_W] ? D_W'(-dx_in) : D_W'(dx_in);
         absy_ff  <= dy_in[D_W] ? D_W'(-dy_in) : D_W'(dy_in);
         s1_nx_ff <= dx_in[D_W];
         s1_ny_ff <= dy_in[D_W];
      end
   end

   // ---------------------------------------------------------------- S2: scale by fov
   logic [MAG_W-1:0] magx_ff;
   logic [MAG_W-1:0] magy_ff;
   logic             s2_nx_ff;
   logic             s2_ny_ff;
   logic             s2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         magx_ff  <= MAG_W'(fov_ff) * MAG_W'(absx_ff);
         magy_ff  <= MAG_W'(fov_ff) * MAG_W'(absy_ff);
         s2_nx_ff <= s1_nx_ff;
         s2_ny_ff <= s1_ny_ff;
      end
   end

   // ---------------------------------------------------------------- S3: rounding bias
   // round(mag / 2W) = (2*mag + 2W) / 4W
   logic [NUM_W-1:0] numx_ff;
   logic [NUM_W-1:0] numy_ff;
   logic             s3_nx_ff;
   logic             s3_ny_ff;
   logic             s3_vld_ff;
   logic [DEN_W-1:0] den;

   assign den = {width_eff, 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         numx_ff  <= NUM_W'({magx_ff, 1'b0}) + NUM_W'({width_eff, 1'b0});
         numy_ff  <= NUM_W'({magy_ff, 1'b0}) + NUM_W'({width_eff, 1'b0});
         s3_nx_ff <= s2_nx_ff;
         s3_ny_ff <= s2_ny_ff;
      end
   end

   // ---------------------------------------------------------------- dividers
   logic             divx_vld;
   logic             divy_vld;
   logic [NUM_W-1:0] qx;
   logic [NUM_W-1:0] qy;
   logic             qx_neg;
   logic             qy_neg;

   prd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_vld_ff),
      .in_num    (numx_ff),
      .in_den    (den),
      .in_neg    (s3_nx_ff),
      .out_valid (divx_vld),
      .out_quot  (qx),
      .out_neg   (qx_neg)
   );

   prd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_vld_ff),
      .in_num    (numy_ff),
      .in_den    (den),
      .in_neg    (s3_ny_ff),
      .out_valid (divy_vld),
      .out_quot  (qy),
      .out_neg   (qy_neg)
   );

   // ---------------------------------------------------------------- S4: angles
   logic signed [ANG_W-1:0] qx_s;
   logic signed [ANG_W-1:0] qy_s;
   logic signed [ANG_W-1:0] phi_ff;
   logic signed [ANG_W-1:0] theta_ff;
   logic                    ang_vld_ff;

   assign qx_s = signed'(ANG_W'(qx));
   assign qy_s = signed'(ANG_W'(qy));

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_vld_ff <= 1'b0;
      end else if (adv) begin
         ang_vld_ff <= divx_vld;
      end
   end

   // polar angle gets the quarter turn
   always_ff @(posedge clock) begin
      if (adv) begin
         phi_ff   <= qx_neg ? -qx_s : qx_s;
         theta_ff <= (qy_neg ? -qy_s : qy_s) + HALF_A;
      end
   end

   // ---------------------------------------------------------------- sin / cos
   logic                  phi_vld;
   logic                  theta_vld;
   logic signed [C_W-1:0] sp;
   logic signed [C_W-1:0] cp;
   logic signed [C_W-1:0] st;
   logic signed [C_W-1:0] ct;

   prd_sincos #(.ANG_W(ANG_W), .FRAC_BITS(FRAC_BITS)) u_sc_phi (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (ang_vld_ff),
      .in_angle  (phi_ff),
      .out_valid (phi_vld),
      .out_sin   (sp),
      .out_cos   (cp)
   );

   prd_sincos #(.ANG_W(ANG_W), .FRAC_BITS(FRAC_BITS)) u_sc_theta (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (ang_vld_ff),
      .in_angle  (theta_ff),
      .out_valid (theta_vld),
      .out_sin   (st),
      .out_cos   (ct)
   );

   // ---------------------------------------------------------------- M1/M2: unit vector
   logic signed [M_W-1:0] pcp_ff;
   logic signed [M_W-1:0] psp_ff;
   logic signed [C_W-1:0] ct_ff;
   logic                  m1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= phi_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pcp_ff <= M_W'(st) * M_W'(cp);
         psp_ff <= M_W'(st) * M_W'(sp);
         ct_ff  <= ct;
      end
   end

   logic signed [V_W-1:0] v_ff [3];
   logic                  m2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff[0] <= V_W'((pcp_ff + RND_M) >>> FRAC_BITS);
         v_ff[1] <= V_W'((psp_ff + RND_M) >>> FRAC_BITS);
         v_ff[2] <= ct_ff;
      end
   end

   // ---------------------------------------------------------------- P1/P2: (0,v) * conj(q)
   // row 0 feeds p0, rows 1..3 feed the vector part
   logic signed [QP_W-1:0] pp_ff [4][3];
   logic                   p1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[0][0] <= QP_W'(v_ff[0]) * QP_W'(qx_ff);
         pp_ff[0][1] <= QP_W'(v_ff[1]) * QP_W'(qy_ff);
         pp_ff[0][2] <= QP_W'(v_ff[2]) * QP_W'(qz_ff);
         pp_ff[1][0] <= QP_W'(qw_ff) * QP_W'(v_ff[0]);
         pp_ff[1][1] <= QP_W'(v_ff[1]) * QP_W'(qz_ff);
         pp_ff[1][2] <= QP_W'(v_ff[2]) * QP_W'(qy_ff);
         pp_ff[2][0] <= QP_W'(qw_ff) * QP_W'(v_ff[1]);
         pp_ff[2][1] <= QP_W'(v_ff[2]) * QP_W'(qx_ff);
         pp_ff[2][2] <= QP_W'(v_ff[0]) * QP_W'(qz_ff);
         pp_ff[3][0] <= QP_W'(qw_ff) * QP_W'(v_ff[2]);
         pp_ff[3][1] <= QP_W'(v_ff[0]) * QP_W'(qy_ff);
         pp_ff[3][2] <= QP_W'(v_ff[1]) * QP_W'(qx_ff);
      end
   end

   logic signed [P_W-1:0] p_ff [4];
   logic                  p2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (adv) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= P_W'((PS_W'(pp_ff[0][0]) + PS_W'(pp_ff[0][1]) + PS_W'(pp_ff[0][2])
                          + RND_P) >>> FRAC_BITS);
         for (int r = 1; r < 4; r++) begin
            p_ff[r] <= P_W'((PS_W'(pp_ff[r][0]) - PS_W'(pp_ff[r][1]) + PS_W'(pp_ff[r][2])
                             + RND_P) >>> FRAC_BITS);
         end
      end
   end

   // ---------------------------------------------------------------- R1/R2: q * p
   logic signed [RP_W-1:0] rp_ff [3][4];
   logic                   r1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
      end else if (adv) begin
         r1_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rp_ff[0][0] <= RP_W'(qw_ff) * RP_W'(p_ff[1]);
         rp_ff[0][1] <= RP_W'(p_ff[0]) * RP_W'(qx_ff);
         rp_ff[0][2] <= RP_W'(qy_ff) * RP_W'(p_ff[3]);
         rp_ff[0][3] <= RP_W'(qz_ff) * RP_W'(p_ff[2]);
         rp_ff[1][0] <= RP_W'(qw_ff) * RP_W'(p_ff[2]);
         rp_ff[1][1] <= RP_W'(p_ff[0]) * RP_W'(qy_ff);
         rp_ff[1][2] <= RP_W'(qz_ff) * RP_W'(p_ff[1]);
         rp_ff[1][3] <= RP_W'(qx_ff) * RP_W'(p_ff[3]);
         rp_ff[2][0] <= RP_W'(qw_ff) * RP_W'(p_ff[3]);
         rp_ff[2][1] <= RP_W'(p_ff[0]) * RP_W'(qz_ff);
         rp_ff[2][2] <= RP_W'(qx_ff) * RP_W'(p_ff[2]);
         rp_ff[2][3] <= RP_W'(qy_ff) * RP_W'(p_ff[1]);
      end
   end

   logic signed [R_W-1:0] r_ff [3];
   logic                  r2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_vld_ff <= 1'b0;
      end else if (adv) begin
         r2_vld_ff <= r1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            r_ff[c] <= R_W'((RS_W'(rp_ff[c][0]) + RS_W'(rp_ff[c][1]) + RS_W'(rp_ff[c][2])
                             - RS_W'(rp_ff[c][3]) + RND_R) >>> FRAC_BITS);
         end
      end
   end

   // ---------------------------------------------------------------- saturate
   logic signed [SAT_W-1:0] sat [3];
   dir_type                 word_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sat[c] = SAT_W'(r_ff[c]);
         if (sat[c] > LIM) begin
            sat[c] = LIM;
         end else if (sat[c] < -LIM) begin
            sat[c] = -LIM;
         end
      end
      word_in.x = sat[0][DIR_W-1:0];
      word_in.y = sat[1][DIR_W-1:0];
      word_in.z = sat[2][DIR_W-1:0];
   end

   // ---------------------------------------------------------------- output buffer
   // two entries: buf_ff[0] is the head shown on rsp
   dir_type    buf_ff [2];
   logic [1:0] cnt_in;

   assign push = r2_vld_ff && adv;
   assign pop  = (cnt_ff != 2'd0) && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         // shift the second entry forward, or refill the head
         if (cnt_ff == 2'd2) begin
            buf_ff[0] <= buf_ff[1];
         end else if (push) begin
            buf_ff[0] <= word_in;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            buf_ff[0] <= word_in;
         end else begin
            buf_ff[1] <= word_in;
         end
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_dir_x = buf_ff[0].x;
   assign rsp_dir_y = buf_ff[0].y;
   assign rsp_dir_z = buf_ff[0].z;

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (phi_vld == theta_vld) && (divx_vld == divy_vld))
      else $error("parallel lanes lost lockstep");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !push)
      else $error("output buffer written while full");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == 2'($past(cnt_ff) + 2'd1)))
      else $error("output buffer count mismatch");
`endif

endmodule

@@ hw/rtl/prd_div.sv @@
module prd_div
   import prd_pkg::*;
#(
   parameter int NUM_W = 32,
   parameter int DEN_W = 15
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic             in_neg,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic             out_neg
);

   // One quotient bit per stage, MSB first; acc shifts numerator out, quotient in
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] acc_ff [NUM_W];
   logic             neg_ff [NUM_W];
   logic             vld_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] acc_prev;
      logic             neg_prev;
      logic             vld_prev;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] acc_in;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign acc_prev = in_num;
         assign neg_prev = in_neg;
         assign vld_prev = in_valid;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign acc_prev = acc_ff[k-1];
         assign neg_prev = neg_ff[k-1];
         assign vld_prev = vld_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, acc_prev[NUM_W-1]};
         ge     = (trial >= {1'b0, in_den});
         rem_in = ge ? DEN_W'(trial - {1'b0, in_den}) : trial[DEN_W-1:0];
         acc_in = {acc_prev[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            acc_ff[k] <= acc_in;
            neg_ff[k] <= neg_prev;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = acc_ff[NUM_W-1];
   assign out_neg   = neg_ff[NUM_W-1];

endmodule

@@ hw/rtl/prd_sincos.sv @@
module prd_sincos
   import prd_pkg::*;
#(
   parameter int ANG_W     = 36,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] in_angle,
   output logic                    out_valid,
   output logic signed [FRAC_BITS+3:0] out_sin,
   output logic signed [FRAC_BITS+3:0] out_cos
);

   localparam int C_W   = FRAC_BITS + 4;
   localparam int RC_W  = ANG_W - FRAC_BITS - 2;
   localparam int PR_W  = ANG_W + RC_W;
   localparam longint TP_L = 2 * from_q30(PI_Q30, FRAC_BITS);
   localparam logic [RC_W-1:0]  RECIP = RC_W'((longint'(1) << ANG_W) / TP_L);
   localparam logic [ANG_W-1:0] TP_A  = ANG_W'(TP_L);
   localparam logic signed [C_W-1:0] TP_C   = C_W'(2 * from_q30(PI_Q30, FRAC_BITS));
   localparam logic signed [C_W-1:0] PI_C   = C_W'(from_q30(PI_Q30, FRAC_BITS));
   localparam logic signed [C_W-1:0] HALF_C = C_W'(from_q30(HALF_PI_Q30, FRAC_BITS));
   localparam logic signed [C_W-1:0] GAIN_C = C_W'(from_q30(GAIN_Q30, FRAC_BITS));

   // Magnitude stage
   logic [ANG_W-1:0] mag_ff;
   logic             mag_neg_ff;
   logic             mag_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_vld_ff <= 1'b0;
      end else if (en) begin
         mag_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff     <= in_angle[ANG_W-1] ? ANG_W'(-in_angle) : ANG_W'(in_angle);
         mag_neg_ff <= in_angle[ANG_W-1];
      end
   end

   // Magnitude mod 2*pi: estimate the turn count by reciprocal multiply
   // (never over, at most one short), subtract the turns, then fix up once
   logic [PR_W-1:0]  est_ff;
   logic [ANG_W-1:0] est_mag_ff;
   logic             est_neg_ff;
   logic             est_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_vld_ff <= 1'b0;
      end else if (en) begin
         est_vld_ff <= mag_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         est_ff     <= PR_W'(mag_ff) * PR_W'(RECIP);
         est_mag_ff <= mag_ff;
         est_neg_ff <= mag_neg_ff;
      end
   end

   logic [RC_W-1:0]  turns;
   logic [ANG_W-1:0] sub_ff;
   logic [ANG_W-1:0] sub_mag_ff;
   logic             sub_neg_ff;
   logic             sub_vld_ff;

   assign turns = est_ff[PR_W-1:ANG_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_vld_ff <= 1'b0;
      end else if (en) begin
         sub_vld_ff <= est_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sub_ff     <= ANG_W'(turns) * TP_A;
         sub_mag_ff <= est_mag_ff;
         sub_neg_ff <= est_neg_ff;
      end
   end

   logic [ANG_W-1:0] left;
   logic [ANG_W-1:0] red_in;
   logic [ANG_W-1:0] red_ff;
   logic             red_neg_ff;
   logic             red_vld_ff;

   always_comb begin
      left   = sub_mag_ff - sub_ff;
      red_in = (left >= TP_A) ? left - TP_A : left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_vld_ff <= 1'b0;
      end else if (en) begin
         red_vld_ff <= sub_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff     <= red_in;
         red_neg_ff <= sub_neg_ff;
      end
   end

   // Restore sign, wrap into [-pi, pi)
   logic signed [C_W-1:0] mr;
   logic signed [C_W-1:0] wr;
   logic signed [C_W-1:0] wrap_in;
   logic signed [C_W-1:0] wrap_ff;
   logic                  wrap_vld_ff;

   always_comb begin
      mr      = signed'(C_W'(red_ff));
      wr      = (red_neg_ff && (mr != '0)) ? TP_C - mr : mr;
      wrap_in = (wr >= PI_C) ? wr - TP_C : wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_vld_ff <= 1'b0;
      end else if (en) begin
         wrap_vld_ff <= red_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff <= wrap_in;
      end
   end

   // Reflect into [-pi/2, pi/2]
   logic signed [C_W-1:0] fold_in;
   logic                  fneg_in;
   logic signed [C_W-1:0] fold_ff;
   logic                  fneg_ff;
   logic                  fold_vld_ff;

   always_comb begin
      fold_in = wrap_ff;
      fneg_in = 1'b0;
      if (wrap_ff > HALF_C) begin
         fold_in = PI_C - wrap_ff;
         fneg_in = 1'b1;
      end else if (wrap_ff < -HALF_C) begin
         fold_in = -PI_C - wrap_ff;
         fneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_vld_ff <= 1'b0;
      end else if (en) begin
         fold_vld_ff <= wrap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff <= fold_in;
         fneg_ff <= fneg_in;
      end
   end

   // CORDIC rotation, one micro-rotation per stage
   logic signed [C_W-1:0] x_ff   [FRAC_BITS];
   logic signed [C_W-1:0] y_ff   [FRAC_BITS];
   logic signed [C_W-1:0] z_ff   [FRAC_BITS];
   logic                  cn_ff  [FRAC_BITS];
   logic                  cv_ff  [FRAC_BITS];

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cordic
      localparam logic signed [C_W-1:0] ATAN_C = C_W'(from_q30(atan_q30(i), FRAC_BITS));
      logic signed [C_W-1:0] x_prev;
      logic signed [C_W-1:0] y_prev;
      logic signed [C_W-1:0] z_prev;
      logic                  n_prev;
      logic                  v_prev;
      logic signed [C_W-1:0] dx;
      logic signed [C_W-1:0] dy;
      logic signed [C_W-1:0] x_in;
      logic signed [C_W-1:0] y_in;
      logic signed [C_W-1:0] z_in;

      if (i == 0) begin : g_first
         assign x_prev = GAIN_C;
         assign y_prev = '0;
         assign z_prev = fold_ff;
         assign n_prev = fneg_ff;
         assign v_prev = fold_vld_ff;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
         assign n_prev = cn_ff[i-1];
         assign v_prev = cv_ff[i-1];
      end

      always_comb begin
         dx = y_prev >>> i;
         dy = x_prev >>> i;
         if (!z_prev[C_W-1]) begin
            x_in = x_prev - dx;
            y_in = y_prev + dy;
            z_in = z_prev - ATAN_C;
         end else begin
            x_in = x_prev + dx;
            y_in = y_prev - dy;
            z_in = z_prev + ATAN_C;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else if (en) begin
            cv_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]  <= x_in;
            y_ff[i]  <= y_in;
            z_ff[i]  <= z_in;
            cn_ff[i] <= n_prev;
         end
      end
   end

   // Apply cosine sign
   logic signed [C_W-1:0] sin_ff;
   logic signed [C_W-1:0] cos_ff;
   logic                  out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= cv_ff[FRAC_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= y_ff[FRAC_BITS-1];
         cos_ff <= cn_ff[FRAC_BITS-1] ? -x_ff[FRAC_BITS-1] : x_ff[FRAC_BITS-1];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

endmodule
